// File: rtl/core/assert_macros.svh
// assertion helpers, sampled on clk_i and idle while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("check failed");

`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// File: rtl/core/wrdc_pkg.sv
package wrdc_pkg;

  localparam logic [31:0] LogMagic  = 32'h004C_4157;
  localparam logic [31:0] CrcPoly   = 32'h82F6_3B78;
  localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;
  localparam logic [16:0] HdrBytes  = 17'd16;
  localparam logic [15:0] UpdMinLen = 16'd12;
  localparam logic [7:0]  UpdTypeRst = 8'd1;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  localparam logic [1:0] StClean     = 2'd0;
  localparam logic [1:0] StBadMagic  = 2'd1;
  localparam logic [1:0] StTruncated = 2'd2;
  localparam logic [1:0] StCrcBad    = 2'd3;

  localparam logic KindRecord = 1'b0;
  localparam logic KindEnd    = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  record_type;
    logic [63:0] transaction_id;
    logic [15:0] payload_length;
    logic [31:0] byte_offset;
    logic [31:0] table_number;
    logic [31:0] row_number;
    logic [15:0] before_length;
    logic [15:0] after_length;
    logic        update_fields_valid;
    logic [1:0]  end_status;
    logic        last_result;
  } res_t;

  typedef struct packed {
    logic v0;
    logic v1;
  } push_t;

  typedef struct packed {
    logic [FifoAw:0] level;
    logic            room;
  } fifo_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

// File: rtl/core/wal_record_deframer_crc32c_top.sv
// log record deframer with crc-32c check. bytes of a log image enter one per
// request on the in_ channel; each record (16-byte little-endian header with
// magic, type, length and transaction id, then payload, then a crc-32c over
// header and payload) that checks good yields a record result, with table,
// row and before/after lengths for update records (type equal to cfg_wdata_i
// as last written, 1 after reset). bad magic or crc mismatch stops parsing
// until the request flagged final_byte_i, which always yields an end report
// with status and valid prefix length, then the block restarts for a new
// image. throughput is one byte per clock while the queue has room: a byte
// sits in the input register while the header/crc logic updates the parse
// state, and its results (zero, one or two) land in a four-entry result
// queue that drains one result per cycle while out_stall_i is low. the input
// stalls only while the queue has fewer than two free slots.
`include "assert_macros.svh"

module wal_record_deframer_crc32c_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  log_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  record_type_o,
  output logic [63:0] transaction_id_o,
  output logic [15:0] payload_length_o,
  output logic [31:0] byte_offset_o,
  output logic [31:0] table_number_o,
  output logic [31:0] row_number_o,
  output logic [15:0] before_length_o,
  output logic [15:0] after_length_o,
  output logic        update_fields_valid_o,
  output logic [1:0]  end_status_o,
  output logic        last_result_o
);

  // update type register
  logic [7:0] upd_code_q;

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  logic       fin_q;
  logic       accept, step;

  wrdc_pkg::push_t      push;
  wrdc_pkg::res_t       res0, res1, head;
  wrdc_pkg::fifo_stat_t fstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_code_q <= wrdc_pkg::UpdTypeRst;
    end else if (cfg_we_i) begin
      upd_code_q <= cfg_wdata_i;
    end
  end

  // the held byte advances whenever the queue can take two more results
  assign step       = in_vld_q && fstat.room;
  assign in_stall_o = in_vld_q && !fstat.room;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= log_byte_i;
      fin_q  <= final_byte_i;
    end
  end

  wrdc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .log_byte_i   (byte_q),
    .final_byte_i (fin_q),
    .upd_code_i   (upd_code_q),
    .push_o       (push),
    .res0_o       (res0),
    .res1_o       (res1)
  );

  wrdc_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .res0_i     (res0),
    .res1_i     (res1),
    .pop_i      (!out_stall_i),
    .head_o     (head),
    .nonempty_o (out_valid_o),
    .stat_o     (fstat)
  );

  assign result_kind_o         = head.result_kind;
  assign record_type_o         = head.record_type;
  assign transaction_id_o      = head.transaction_id;
  assign payload_length_o      = head.payload_length;
  assign byte_offset_o         = head.byte_offset;
  assign table_number_o        = head.table_number;
  assign row_number_o          = head.row_number;
  assign before_length_o       = head.before_length;
  assign after_length_o        = head.after_length;
  assign update_fields_valid_o = head.update_fields_valid;
  assign end_status_o          = head.end_status;
  assign last_result_o         = head.last_result;

  // queue never overfills
  `CHK_PROP(a_level_max, fstat.level <= (wrdc_pkg::FifoAw + 1)'(wrdc_pkg::FifoDepth))
  // a final byte always leaves a result in the queue
  `CHK_IMPL(a_final_res, step && fin_q, out_valid_o)
  // a stall only ever holds an occupied input register
  `CHK_PROP(a_stall_full, in_stall_o |-> in_vld_q)
  // two results pushed together always pair a record with the end report
  `CHK_PROP(a_pair_order, push.v1 |-> (res0.result_kind == wrdc_pkg::KindRecord &&
                                       res1.result_kind == wrdc_pkg::KindEnd))

endmodule

// File: rtl/core/wrdc_parser.sv
module wrdc_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           log_byte_i,
  input  logic                 final_byte_i,
  input  logic [7:0]           upd_code_i,
  output wrdc_pkg::push_t      push_o,
  output wrdc_pkg::res_t       res0_o,
  output wrdc_pkg::res_t       res1_o
);

  logic [16:0] pos_q, pos_d;
  logic [31:0] off_q, off_d, start_q, start_d, crc_q, crc_d, hw_q, hw_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] len_q, len_d, bl_q, bl_d, al_q, al_d;
  logic [63:0] id_q, id_d;
  logic [31:0] tab_q, tab_d, row_q, row_d;
  logic [1:0]  seen_q, seen_d, stst_q, stst_d;
  logic        stop_q, stop_d;
  logic [16:0] data_end, q;
  logic [17:0] al_pos;
  logic [1:0]  k;
  logic        done, upd, valid_upd, rec_v, end_v;
  wrdc_pkg::res_t rec, endr;

  always_comb begin
    pos_d = pos_q; off_d = off_q; start_d = start_q; crc_d = crc_q; hw_d = hw_q;
    type_d = type_q; len_d = len_q; id_d = id_q; tab_d = tab_q; row_d = row_q;
    bl_d = bl_q; al_d = al_q; seen_d = seen_q; stst_d = stst_q; stop_d = stop_q;
    done = 1'b0; rec_v = 1'b0; end_v = 1'b0;
    data_end = '0; q = '0; al_pos = '0; k = '0; upd = 1'b0; valid_upd = 1'b0;
    rec = '0; endr = '0;
    if (!stop_q) begin
      if (pos_q == 17'd0) begin
        start_d = off_q; crc_d = wrdc_pkg::CrcInit; hw_d = '0;
        type_d = '0; len_d = '0; id_d = '0; tab_d = '0; row_d = '0;
        bl_d = '0; al_d = '0; seen_d = '0;
      end
      if (pos_q < wrdc_pkg::HdrBytes) begin
        crc_d = wrdc_pkg::crc_byte(crc_d, log_byte_i);
        if (pos_q < 17'd4) begin
          hw_d[8*pos_q[1:0] +: 8] = log_byte_i;
          if (pos_q == 17'd3 && hw_d != wrdc_pkg::LogMagic) begin
            stop_d = 1'b1; stst_d = wrdc_pkg::StBadMagic;
          end
        end else if (pos_q == 17'd4) begin
          type_d = log_byte_i;
        end else if (pos_q == 17'd6) begin
          len_d[7:0] = log_byte_i;
        end else if (pos_q == 17'd7) begin
          len_d[15:8] = log_byte_i;
        end else if (pos_q >= 17'd8) begin
          id_d[8*pos_q[2:0] +: 8] = log_byte_i;
        end
      end else begin
        data_end = wrdc_pkg::HdrBytes + {1'b0, len_q};
        if (pos_q < data_end) begin
          q = pos_q - wrdc_pkg::HdrBytes;
          al_pos = 18'd10 + {2'd0, bl_q} + {16'd0, seen_q};
          crc_d = wrdc_pkg::crc_byte(crc_d, log_byte_i);
          if (q < 17'd4) begin
            tab_d[8*q[1:0] +: 8] = log_byte_i;
          end else if (q < 17'd8) begin
            row_d[8*q[1:0] +: 8] = log_byte_i;
          end else if (q == 17'd8) begin
            bl_d[7:0] = log_byte_i;
          end else if (q == 17'd9) begin
            bl_d[15:8] = log_byte_i;
          end else if (seen_q < 2'd2 && {1'b0, q} == al_pos) begin
            al_d[8*seen_q[0] +: 8] = log_byte_i;
            seen_d = seen_q + 2'd1;
          end
        end else begin
          k = pos_q[1:0] - data_end[1:0];
          if (k == 2'd0) begin
            hw_d = {24'd0, log_byte_i};
          end else begin
            hw_d[8*k +: 8] = log_byte_i;
          end
          if (k == 2'd3) begin
            if (hw_d == ~crc_q) begin
              upd = (type_q == upd_code_i) && (len_q >= wrdc_pkg::UpdMinLen);
              valid_upd = upd && (seen_q == 2'd2);
              rec_v = 1'b1;
              rec.result_kind = wrdc_pkg::KindRecord;
              rec.record_type = type_q;
              rec.transaction_id = id_q;
              rec.payload_length = len_q;
              rec.byte_offset = start_d;
              rec.table_number = upd ? tab_q : 32'd0;
              rec.row_number = upd ? row_q : 32'd0;
              rec.before_length = upd ? bl_q : 16'd0;
              rec.after_length = valid_upd ? al_q : 16'd0;
              rec.update_fields_valid = valid_upd;
              rec.end_status = wrdc_pkg::StClean;
              rec.last_result = !final_byte_i;
              start_d = off_q + 32'd1;
              done = 1'b1;
            end else begin
              stop_d = 1'b1; stst_d = wrdc_pkg::StCrcBad;
            end
          end
        end
      end
      if (!stop_d) begin
        pos_d = done ? 17'd0 : pos_q + 17'd1;
      end
      off_d = off_q + 32'd1;
    end
    if (final_byte_i) begin
      end_v = 1'b1;
      endr.result_kind = wrdc_pkg::KindEnd;
      endr.byte_offset = start_d;
      endr.end_status = stop_d ? stst_d
                      : (pos_d != 17'd0 ? wrdc_pkg::StTruncated : wrdc_pkg::StClean);
      endr.last_result = 1'b1;
      pos_d = '0; off_d = '0; start_d = '0; crc_d = wrdc_pkg::CrcInit; hw_d = '0;
      type_d = '0; len_d = '0; id_d = '0; tab_d = '0; row_d = '0;
      bl_d = '0; al_d = '0; seen_d = '0; stst_d = wrdc_pkg::StClean; stop_d = 1'b0;
    end
  end

  always_comb begin
    push_o.v0 = step_i && (rec_v || end_v);
    push_o.v1 = step_i && rec_v && end_v;
    res0_o = rec_v ? rec : endr;
    res1_o = endr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; off_q <= '0; start_q <= '0; crc_q <= wrdc_pkg::CrcInit; hw_q <= '0;
      type_q <= '0; len_q <= '0; id_q <= '0; tab_q <= '0; row_q <= '0;
      bl_q <= '0; al_q <= '0; seen_q <= '0; stst_q <= wrdc_pkg::StClean; stop_q <= 1'b0;
    end else if (step_i) begin
      pos_q <= pos_d; off_q <= off_d; start_q <= start_d; crc_q <= crc_d; hw_q <= hw_d;
      type_q <= type_d; len_q <= len_d; id_q <= id_d; tab_q <= tab_d; row_q <= row_d;
      bl_q <= bl_d; al_q <= al_d; seen_q <= seen_d; stst_q <= stst_d; stop_q <= stop_d;
    end
  end

endmodule

// File: rtl/core/wrdc_res_fifo.sv
module wrdc_res_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wrdc_pkg::push_t      push_i,
  input  wrdc_pkg::res_t       res0_i,
  input  wrdc_pkg::res_t       res1_i,
  input  logic                 pop_i,
  output wrdc_pkg::res_t       head_o,
  output logic                 nonempty_o,
  output wrdc_pkg::fifo_stat_t stat_o
);

  localparam int unsigned Aw = wrdc_pkg::FifoAw;

  wrdc_pkg::res_t mem_q [wrdc_pkg::FifoDepth];
  logic [Aw-1:0]  wr_q, wr_d, rd_q, rd_d, wr1;
  logic [Aw:0]    cnt_q, cnt_d;
  logic           do_pop;

  assign wr1 = wr_q + {{(Aw-1){1'b0}}, 1'b1};
  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (push_i.v0) begin
      wr_d = push_i.v1 ? wr_q + Aw'(2) : wr1;
    end
    if (do_pop) begin
      rd_d = rd_q + {{(Aw-1){1'b0}}, 1'b1};
    end
    cnt_d = cnt_q + {{Aw{1'b0}}, push_i.v0} + {{Aw{1'b0}}, push_i.v1}
          - {{Aw{1'b0}}, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_q] <= res0_i;
    end
    if (push_i.v1) begin
      mem_q[wr1] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o = mem_q[rd_q];
  assign nonempty_o = (cnt_q != '0);
  assign stat_o.level = cnt_q;
  // two free slots needed, one request can post a record and an end report
  assign stat_o.room = (cnt_q <= (Aw+1)'(wrdc_pkg::FifoDepth - 2));

endmodule

// File: sim/tb_wal_record_deframer_crc32c_top.sv
`timescale 1ns / 1ps

module tb_wal_record_deframer_crc32c_top;

  // one row of the opening stimulus table; typed rows carry the end status
  typedef struct {
    logic [7:0] b;
    logic       fin;
    bit         typed;
    logic [1:0] st;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'd0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  log_byte_i = 8'd0;
  logic        final_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        result_kind_o;
  logic [7:0]  record_type_o;
  logic [63:0] transaction_id_o;
  logic [15:0] payload_length_o;
  logic [31:0] byte_offset_o;
  logic [31:0] table_number_o;
  logic [31:0] row_number_o;
  logic [15:0] before_length_o;
  logic [15:0] after_length_o;
  logic        update_fields_valid_o;
  logic [1:0]  end_status_o;
  logic        last_result_o;

  wal_record_deframer_crc32c_top dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .log_byte_i            (log_byte_i),
    .final_byte_i          (final_byte_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .result_kind_o         (result_kind_o),
    .record_type_o         (record_type_o),
    .transaction_id_o      (transaction_id_o),
    .payload_length_o      (payload_length_o),
    .byte_offset_o         (byte_offset_o),
    .table_number_o        (table_number_o),
    .row_number_o          (row_number_o),
    .before_length_o       (before_length_o),
    .after_length_o        (after_length_o),
    .update_fields_valid_o (update_fields_valid_o),
    .end_status_o          (end_status_o),
    .last_result_o         (last_result_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // results still owed by the block, oldest first
  wrdc_pkg::res_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned requests_sent = 0;
  bit          idling_on = 1'b1;
  int unsigned stall_left = 0;
  logic [7:0]  image_q[$];

  // parser mirror: position, offsets, crc and captured header/payload fields
  logic [7:0]  upd_code = wrdc_pkg::UpdTypeRst;
  logic [16:0] p_pos;
  logic [31:0] p_off, p_start, p_crc, p_word;
  logic [7:0]  p_type;
  logic [15:0] p_len;
  logic [63:0] p_id;
  logic [31:0] p_table, p_row;
  logic [15:0] p_blen, p_alen;
  logic [1:0]  p_aseen, p_status;
  logic        p_stop;

  task automatic clear_parse();
    p_pos = '0; p_off = '0; p_start = '0; p_crc = '1; p_word = '0;
    p_type = '0; p_len = '0; p_id = '0; p_table = '0; p_row = '0;
    p_blen = '0; p_alen = '0; p_aseen = '0; p_status = wrdc_pkg::StClean; p_stop = 1'b0;
  endtask

  // reflected crc-32c, one byte
  function automatic logic [31:0] crc32c_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) x = x[0] ? ((x >> 1) ^ 32'h82F6_3B78) : (x >> 1);
    return x;
  endfunction

  task automatic predict_deframe(input logic [7:0] b, input logic fin);
    wrdc_pkg::res_t r;
    logic [16:0] pos, data_end;
    int unsigned q, k;
    bit          done, upd, ok;
    done = 1'b0;
    if (!p_stop) begin
      pos = p_pos;
      if (pos == 0) begin
        p_start = p_off; p_crc = '1; p_word = '0; p_type = '0; p_len = '0;
        p_id = '0; p_table = '0; p_row = '0; p_blen = '0; p_alen = '0; p_aseen = '0;
      end
      if (pos < 17'd16) begin
        p_crc = crc32c_next(p_crc, b);
        if (pos < 4) begin
          p_word |= 32'(b) << (8 * pos);
          if (pos == 3 && p_word != wrdc_pkg::LogMagic) begin
            p_stop = 1'b1; p_status = wrdc_pkg::StBadMagic;
          end
        end else if (pos == 4) p_type = b;
        else if (pos == 6) p_len[7:0] = b;
        else if (pos == 7) p_len[15:8] = b;
        else if (pos >= 8) p_id |= 64'(b) << (8 * (pos - 8));
      end else begin
        data_end = 17'd16 + {1'b0, p_len};
        if (pos < data_end) begin
          q = int'(pos) - 16;
          p_crc = crc32c_next(p_crc, b);
          if (q < 4) p_table |= 32'(b) << (8 * q);
          else if (q < 8) p_row |= 32'(b) << (8 * (q - 4));
          else if (q == 8) p_blen[7:0] = b;
          else if (q == 9) p_blen[15:8] = b;
          else if (p_aseen < 2 && q == 10 + int'(p_blen) + int'(p_aseen)) begin
            p_alen |= 16'(b) << (8 * p_aseen);
            p_aseen++;
          end
        end else begin
          k = int'(pos - data_end) & 3;
          if (k == 0) p_word = 32'(b);
          else p_word |= 32'(b) << (8 * k);
          if (k == 3) begin
            if (p_word == ~p_crc) begin
              upd = (p_type == upd_code) && (p_len >= wrdc_pkg::UpdMinLen);
              ok = upd && (p_aseen == 2);
              r = '0;
              r.result_kind = wrdc_pkg::KindRecord;
              r.record_type = p_type;
              r.transaction_id = p_id;
              r.payload_length = p_len;
              r.byte_offset = p_start;
              r.table_number = upd ? p_table : '0;
              r.row_number = upd ? p_row : '0;
              r.before_length = upd ? p_blen : '0;
              r.after_length = ok ? p_alen : '0;
              r.update_fields_valid = ok;
              r.end_status = wrdc_pkg::StClean;
              r.last_result = !fin;
              pending_results = {pending_results, r};
              p_start = p_off + 32'd1;
              done = 1'b1;
            end else begin
              p_stop = 1'b1; p_status = wrdc_pkg::StCrcBad;
            end
          end
        end
      end
      if (!p_stop) p_pos = done ? 17'd0 : pos + 17'd1;
      p_off = p_off + 32'd1;
    end
    if (fin) begin
      r = '0;
      r.result_kind = wrdc_pkg::KindEnd;
      r.byte_offset = p_start;
      r.end_status = p_stop ? p_status
                   : (p_pos != 0 ? wrdc_pkg::StTruncated : wrdc_pkg::StClean);
      r.last_result = 1'b1;
      pending_results = {pending_results, r};
      clear_parse();
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // one byte request; the predictor runs at the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic fin);
    bit acc;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    log_byte_i <= b;
    final_byte_i <= fin;
    acc = 1'b0;
    while (!acc) begin
      @(negedge clk_i);
      acc = !in_stall_o;
      @(posedge clk_i);
    end
    predict_deframe(b, fin);
    requests_sent++;
  endtask

  // header, payload with update fields, then crc; optional damage
  task automatic build_record(input logic [7:0] typ, input logic [15:0] len,
                              input logic [15:0] blen, input bit bad_crc, input bit bad_magic);
    logic [7:0]  hdr[16];
    logic [63:0] id;
    logic [31:0] c;
    logic [7:0]  by;
    id = {$urandom, $urandom};
    hdr[0] = 8'h57; hdr[1] = 8'h41; hdr[2] = 8'h4C; hdr[3] = 8'h00;
    hdr[4] = typ; hdr[5] = 8'($urandom); hdr[6] = len[7:0]; hdr[7] = len[15:8];
    for (int i = 0; i < 8; i++) hdr[8 + i] = id[8 * i +: 8];
    if (bad_magic) hdr[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    c = '1;
    for (int i = 0; i < 16; i++) begin
      c = crc32c_next(c, hdr[i]);
      image_q = {image_q, hdr[i]};
    end
    for (int i = 0; i < int'(len); i++) begin
      by = (i == 8) ? blen[7:0] : (i == 9) ? blen[15:8] : 8'($urandom);
      c = crc32c_next(c, by);
      image_q = {image_q, by};
    end
    c = ~c;
    if (bad_crc) c ^= 32'd1 << $urandom_range(0, 31);
    for (int i = 0; i < 4; i++) image_q = {image_q, c[8 * i +: 8]};
  endtask

  // sends the built image, optionally cut short; last byte is flagged final
  task automatic send_image(input bit cut);
    int n;
    n = image_q.size();
    if (cut) n = $urandom_range(1, n);
    for (int i = 0; i < n; i++) send_byte(image_q[i], i == n - 1);
    image_q.delete();
  endtask

  task automatic rand_image();
    logic [7:0]  typ;
    logic [15:0] len, blen;
    int          sel;
    repeat ($urandom_range(1, 3)) begin
      typ = ($urandom_range(0, 2) != 0) ? upd_code : 8'($urandom);
      sel = $urandom_range(0, 19);
      if (sel == 0) len = 16'($urandom_range(200, 400));
      else if (sel < 4) len = 16'($urandom_range(0, 11));
      else len = 16'($urandom_range(12, 40));
      if ($urandom_range(0, 3) == 0) blen = 16'($urandom);
      else blen = 16'($urandom_range(0, (len >= 12) ? int'(len) - 10 : 2));
      build_record(typ, len, blen, $urandom_range(0, 11) == 0, $urandom_range(0, 14) == 0);
    end
    send_image($urandom_range(0, 3) == 0);
  endtask

  // sender holds off until every owed result is out, then lets the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_update_code(input logic [7:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    upd_code = v;
    cfg_we_i <= 1'b0;
  endtask

  // random receiver stall bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // results are taken at the falling edge, where the handshake is settled
  always @(negedge clk_i) begin
    wrdc_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", result_kind_o, want.result_kind);
        check_field("record_type", record_type_o, want.record_type);
        check_field("transaction_id", transaction_id_o, want.transaction_id);
        check_field("payload_length", payload_length_o, want.payload_length);
        check_field("byte_offset", byte_offset_o, want.byte_offset);
        check_field("table_number", table_number_o, want.table_number);
        check_field("row_number", row_number_o, want.row_number);
        check_field("before_length", before_length_o, want.before_length);
        check_field("after_length", after_length_o, want.after_length);
        check_field("update_fields_valid", update_fields_valid_o, want.update_fields_valid);
        check_field("end_status", end_status_o, want.end_status);
        check_field("last_result", last_result_o, want.last_result);
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(negedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 2000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    dir_row_t       opening[10];
    logic [7:0]     phase_codes[4];
    int unsigned    phase_start;
    wrdc_pkg::res_t typed_end;
    clear_parse();
    // lone final byte: cut short in the magic; bad magic flagged on its fourth
    // byte; zero magic with an extra final byte; good magic cut in the header
    opening = '{
      '{8'h00, 1'b1, 1'b1, wrdc_pkg::StTruncated},
      '{8'h57, 1'b0, 1'b0, wrdc_pkg::StClean},
      '{8'h41, 1'b0, 1'b0, wrdc_pkg::StClean},
      '{8'h4C, 1'b0, 1'b0, wrdc_pkg::StClean},
      '{8'hFF, 1'b1, 1'b1, wrdc_pkg::StBadMagic},
      '{8'h00, 1'b0, 1'b0, wrdc_pkg::StClean},
      '{8'h00, 1'b0, 1'b0, wrdc_pkg::StClean},
      '{8'h00, 1'b0, 1'b0, wrdc_pkg::StClean},
      '{8'h00, 1'b0, 1'b0, wrdc_pkg::StClean},
      '{8'hFF, 1'b1, 1'b1, wrdc_pkg::StBadMagic}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) begin
      send_byte(opening[i].b, opening[i].fin);
      if (opening[i].typed) begin
        typed_end = '0;
        typed_end.result_kind = wrdc_pkg::KindEnd;
        typed_end.end_status = opening[i].st;
        typed_end.last_result = 1'b1;
        pending_results[pending_results.size() - 1] = typed_end;
      end
    end
    // good magic, cut in the header
    image_q = '{8'h57, 8'h41, 8'h4C, 8'h00, 8'h01};
    send_image(1'b0);

    // short well-formed images under the reset code: empty update record, update
    // with after-length inside, after-length past the payload, a plain record, bad crc
    build_record(upd_code, 16'd0, 16'd0, 1'b0, 1'b0);
    send_image(1'b0);
    build_record(upd_code, 16'd12, 16'd0, 1'b0, 1'b0);
    build_record(upd_code, 16'd14, 16'd3, 1'b0, 1'b0);
    build_record(8'h07, 16'd20, 16'd2, 1'b0, 1'b0);
    send_image(1'b0);
    build_record(upd_code, 16'd16, 16'd1, 1'b1, 1'b0);
    build_record(upd_code, 16'd16, 16'd1, 1'b0, 1'b0);
    send_image(1'b0);
    drain();

    // code extremes, a random one, then back to the reset value without idling
    phase_codes = '{8'h00, 8'hFF, 8'($urandom), wrdc_pkg::UpdTypeRst};
    foreach (phase_codes[p]) begin
      write_update_code(phase_codes[p]);
      if (p == 3) idling_on = 1'b0;
      phase_start = requests_sent;
      while (requests_sent - phase_start < 300) rand_image();
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/wrdc_pkg.sv
rtl/core/wrdc_parser.sv
rtl/core/wrdc_res_fifo.sv
rtl/core/wal_record_deframer_crc32c_top.sv
sim/tb_wal_record_deframer_crc32c_top.sv
